/* rtl/core/sitoa_pkg.sv */
`default_nettype none

package sitoa_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BCD_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // double dabble: a digit of five or more gets three added before the shift
  localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_W-1:0] BCD_ADJ     = 4'd3;

endpackage

`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii.sv */
`default_nettype none

// Signed integer to decimal ASCII text.
// Input channel (in_valid/in_ready/in_value) takes one two's complement
// value. Output channel (out_valid/out_ready/out_character/out_last) gives
// its text one character per request: '-' for a negative value, then the
// digits most significant first, no leading zeros. out_last marks the final
// character. The most negative value prints as '-' and its magnitude, read unsigned.
// Each value is converted in the double-dabble unit (one bit a cycle),
// then its leading zero digits are dropped, one a cycle, then its text is
// loaded one character a cycle while out_ready does not stall. in_ready is
// high only while the block is idle.
// The output is registered: the last character can wait on out_ready while
// the next value is accepted. A stalled out_ready holds the character, and
// holds the sequencer once it has the next character to load.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
module signed_int_to_decimal_ascii
  import sitoa_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic             [CHAR_W-1:0]     out_character,
  output logic                              out_last
);

  // digits of 2^(DATA_WIDTH-1): floor((W-1)*log10(2)) + 1
  localparam int unsigned NUM_DIGITS = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_BITS   = NUM_DIGITS * BCD_W;
  localparam int unsigned BIT_CNT_W  = $clog2(DATA_WIDTH);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGS
  } state_t;

  state_t                state_r,   state_nxt;
  logic [DATA_WIDTH-1:0] mag_r,     mag_nxt;
  logic                  neg_r,     neg_nxt;
  logic [BCD_BITS-1:0]   bcd_r,     bcd_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic                  out_valid_r,     out_valid_nxt;
  logic [CHAR_W-1:0]     out_character_r, out_character_nxt;
  logic                  out_last_r,      out_last_nxt;

  logic [DATA_WIDTH-1:0] in_bits;
  logic [DATA_WIDTH-1:0] in_mag;
  logic [BCD_BITS-1:0]   bcd_step;
  logic [BCD_W-1:0]      top_digit;
  logic                  slot_free;
  logic                  accept;

  sitoa_bcd_step #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_bcd_step (
    .bcd       (bcd_r),
    .shift_bit (mag_r[DATA_WIDTH-1]),
    .bcd_next  (bcd_step)
  );

  assign in_bits   = in_value;
  assign in_mag    = in_bits[DATA_WIDTH-1]
                     ? (~in_bits + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : in_bits;
  assign top_digit = bcd_r[BCD_BITS-1 -: BCD_W];
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt         = state_r;
    mag_nxt           = mag_r;
    neg_nxt           = neg_r;
    bcd_nxt           = bcd_r;
    bit_cnt_nxt       = bit_cnt_r;
    dig_cnt_nxt       = dig_cnt_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_nxt     = in_mag;
          neg_nxt     = in_bits[DATA_WIDTH-1];
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = bcd_step;
        mag_nxt     = {mag_r[DATA_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(DATA_WIDTH - 1)) begin
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          state_nxt   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == '0 && dig_cnt_r != DIG_CNT_W'(1)) begin
          bcd_nxt     = {bcd_r[BCD_BITS-BCD_W-1:0], {BCD_W{1'b0}}};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_DIGS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_MINUS;
          out_last_nxt      = 1'b0;
          state_nxt         = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
          out_last_nxt      = (dig_cnt_r == DIG_CNT_W'(1));
          bcd_nxt           = {bcd_r[BCD_BITS-BCD_W-1:0], {BCD_W{1'b0}}};
          dig_cnt_nxt       = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DIG_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r           <= mag_nxt;
    neg_r           <= neg_nxt;
    bcd_r           <= bcd_nxt;
    bit_cnt_r       <= bit_cnt_nxt;
    dig_cnt_r       <= dig_cnt_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/sitoa_bcd_step.sv */
`default_nettype none

// One double-dabble step: correct each BCD digit, then shift in the next
// magnitude bit.
module sitoa_bcd_step
  import sitoa_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  wire logic [NUM_DIGITS*BCD_W-1:0] bcd,
  input  wire logic                        shift_bit,
  output logic      [NUM_DIGITS*BCD_W-1:0] bcd_next
);

  logic [NUM_DIGITS*BCD_W-1:0] adjusted;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*BCD_W +: BCD_W] >= BCD_ADJ_MIN) begin
        adjusted[i*BCD_W +: BCD_W] = bcd[i*BCD_W +: BCD_W] + BCD_ADJ;
      end else begin
        adjusted[i*BCD_W +: BCD_W] = bcd[i*BCD_W +: BCD_W];
      end
    end
  end

  assign bcd_next = {adjusted[NUM_DIGITS*BCD_W-2:0], shift_bit};

endmodule

`default_nettype wire

/* rtl/core/sitoa_checker.sv */
`default_nettype none

module sitoa_checker
  import sitoa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] out_character,
  input wire logic              out_last
);

  // stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output character changed");

  // one value at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready the cycle after an accepted request");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE)))
    else $error("output character is not a sign or a digit");

  // a sign is always followed by at least one digit
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == CHAR_MINUS) |-> !out_last)
    else $error("sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last      (out_last)
);

`default_nettype wire
